// File: hdl/pmeq_pkg.sv
`default_nettype none

package pmeq_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;
    localparam int COEF_W     = 7;
    localparam int PIDX_W     = 5;
    localparam int NCOEF_PORT = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'b1;

    localparam logic [COEF_W-1:0] Q_LO      = 7'd31;
    localparam logic [COEF_W-1:0] Q_HI      = 7'd127;
    localparam logic [PIDX_W-1:0] LEN_SHORT = 5'd3;

    typedef struct packed {
        logic [COEF_W-1:0] coeff_0;
        logic [COEF_W-1:0] coeff_1;
        logic [COEF_W-1:0] coeff_2;
        logic [COEF_W-1:0] coeff_3;
        logic [COEF_W-1:0] coeff_4;
        logic [COEF_W-1:0] coeff_5;
        logic [COEF_W-1:0] coeff_6;
        logic [COEF_W-1:0] coeff_7;
        logic [COEF_W-1:0] coeff_8;
        logic [COEF_W-1:0] coeff_9;
        logic              last_column;
    } pmeq_in_t;

    typedef struct packed {
        logic [PIDX_W-1:0] point_index;
        logic [COEF_W-1:0] value;
        logic              last_point;
        logic              end_of_batch;
    } pmeq_out_t;

    typedef struct packed {
        logic              valid;
        logic [PIDX_W-1:0] point_index;
        logic              last_point;
        logic              end_of_batch;
        logic [COEF_W-1:0] x;
    } pmeq_ctl_t;

    // fold by 2^7 = 1 mod 127, or by 2^5 = 1 mod 31, then one conditional subtract
    function automatic logic [COEF_W-1:0] pmeq_reduce(input logic [13:0] v,
                                                      input logic q_sel);
        logic [7:0]        s;
        logic [6:0]        t;
        logic [5:0]        u;
        logic [COEF_W-1:0] r;
        s = {1'b0, v[13:7]} + {1'b0, v[6:0]};
        t = {3'b000, v[13:10]} + {2'b00, v[9:5]} + {2'b00, v[4:0]};
        u = {4'b0000, t[6:5]} + {1'b0, t[4:0]};
        if (q_sel)
        begin
            r = (s >= 8'd127) ? 7'(s - 8'd127) : s[6:0];
        end
        else
        begin
            r = (u >= 6'd31) ? {1'b0, u - 6'd31} : {1'b0, u};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/pmeq_horner_stage.sv
`default_nettype none

module pmeq_horner_stage
    import pmeq_pkg::*;
#(
    parameter int NC   = 10,
    parameter int STEP = 1
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_sel,
    input  wire pmeq_ctl_t                   prev_ctl,
    input  wire logic [COEF_W-1:0]           prev_acc,
    input  wire logic [NC-1:0][COEF_W-1:0]   prev_coef,
    output pmeq_ctl_t                        ctl_reg,
    output logic [COEF_W-1:0]                acc_reg,
    output logic [NC-1:0][COEF_W-1:0]        coef_reg
);

    localparam int CIDX = NC - 1 - STEP;

    logic [13:0]       mac;
    logic [COEF_W-1:0] acc_next;

    assign mac = {7'b0, prev_acc} * {7'b0, prev_ctl.x} + {7'b0, prev_coef[CIDX]};
    assign acc_next = pmeq_reduce(mac, q_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= prev_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        coef_reg <= prev_coef;
    end

endmodule

`default_nettype wire

// File: hdl/poly_multipoint_eval_mod_q_top.sv
`default_nettype none

// Evaluates one polynomial column over GF(q) per accepted item and emits 2L-1 results
// (f(0), f(k) and f(-k) for k = 1..L-2, f(L-1), then the leading coefficient), one per
// cycle with valid high for exactly that cycle; the receiver cannot stall, so every
// result must be captured as it appears. An item is taken when start is high and busy
// is low; the point sequencer issues one evaluation point a cycle, busy dropping in
// the cycle the last point of the current item issues, so the next item can be taken
// in that cycle. Each point passes the issue register stage_ctl[0] and then a Horner
// pipeline of MAX_COEFFS-1 multiply-and-reduce stages before the result reaches the
// ports. Change configuration only while no results are pending.

module poly_multipoint_eval_mod_q_top
    import pmeq_pkg::*;
#(
    parameter int MAX_COEFFS = 10
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire pmeq_in_t              item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       valid,
    output pmeq_out_t                  result
);

    localparam int NC    = MAX_COEFFS;
    localparam int NSTEP = NC - 1;
    localparam logic [PIDX_W-1:0] LEN_LONG = PIDX_W'(NC);

    logic qsel_reg;
    logic lsel_reg;

    logic [COEF_W-1:0]         raw [NCOEF_PORT];
    logic [NC-1:0][COEF_W-1:0] in_coef;
    logic [PIDX_W-1:0]         len_w;
    logic [PIDX_W-1:0]         last_p;
    logic [COEF_W-1:0]         q_val;

    logic                      active_reg;
    logic                      active_next;
    logic [PIDX_W-1:0]         p_reg;
    logic [PIDX_W-1:0]         p_next;
    logic [NC-1:0][COEF_W-1:0] coef_reg;
    logic                      last_col_reg;
    logic                      at_last;
    logic                      accept;

    pmeq_ctl_t                 iss_ctl;
    logic [NC-1:0][COEF_W-1:0] iss_coef;
    logic [COEF_W-1:0]         lead;
    logic [PIDX_W-1:0]         p_inc;

    pmeq_ctl_t                 stage_ctl  [NSTEP+1];
    logic [COEF_W-1:0]         stage_acc  [NSTEP+1];
    logic [NC-1:0][COEF_W-1:0] stage_coef [NSTEP+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsel_reg <= 1'b0;
            lsel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS: qsel_reg <= cfg_data[0];
                REG_LENGTH:  lsel_reg <= cfg_data[0];
            endcase
        end
    end

    assign raw[0] = item.coeff_0;
    assign raw[1] = item.coeff_1;
    assign raw[2] = item.coeff_2;
    assign raw[3] = item.coeff_3;
    assign raw[4] = item.coeff_4;
    assign raw[5] = item.coeff_5;
    assign raw[6] = item.coeff_6;
    assign raw[7] = item.coeff_7;
    assign raw[8] = item.coeff_8;
    assign raw[9] = item.coeff_9;

    assign len_w  = lsel_reg ? LEN_LONG : LEN_SHORT;
    assign last_p = {len_w[PIDX_W-2:0], 1'b0} - PIDX_W'(2);
    assign q_val  = qsel_reg ? Q_HI : Q_LO;

    // reduce and zero the coefficients above the selected length
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            in_coef[i] = (PIDX_W'(i) < len_w) ? pmeq_reduce({7'b0, raw[i]}, qsel_reg)
                                              : '0;
        end
    end

    assign at_last = (p_reg == last_p);
    assign busy    = active_reg && !at_last;
    assign accept  = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        p_next      = p_reg;
        if (accept)
        begin
            active_next = 1'b1;
            p_next      = '0;
        end
        else if (active_reg && at_last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            p_next = p_reg + PIDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            p_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            p_reg      <= p_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            coef_reg     <= in_coef;
            last_col_reg <= item.last_column;
        end
    end

    // point at infinity: evaluate at zero with the leading coefficient moved to degree 0
    assign lead  = lsel_reg ? coef_reg[NC-1] : coef_reg[2];
    assign p_inc = p_reg + PIDX_W'(1);

    always_comb
    begin
        iss_ctl.valid        = active_reg;
        iss_ctl.point_index  = p_reg;
        iss_ctl.last_point   = at_last;
        iss_ctl.end_of_batch = at_last && last_col_reg;
        if (at_last || (p_reg == '0))
        begin
            iss_ctl.x = '0;
        end
        else if (p_reg[0])
        begin
            iss_ctl.x = {{(COEF_W-PIDX_W+1){1'b0}}, p_inc[PIDX_W-1:1]};
        end
        else
        begin
            iss_ctl.x = q_val - {{(COEF_W-PIDX_W+1){1'b0}}, p_reg[PIDX_W-1:1]};
        end
        for (int i = 0; i < NC; i++)
        begin
            if (at_last)
            begin
                iss_coef[i] = (i == 0) ? lead : '0;
            end
            else
            begin
                iss_coef[i] = coef_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_ctl[0] <= '0;
        end
        else
        begin
            stage_ctl[0] <= iss_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_acc[0]  <= iss_coef[NC-1];
        stage_coef[0] <= iss_coef;
    end

    for (genvar j = 1; j <= NSTEP; j++)
    begin : g_step
        pmeq_horner_stage #(
            .NC   (NC),
            .STEP (j)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .q_sel     (qsel_reg),
            .prev_ctl  (stage_ctl[j-1]),
            .prev_acc  (stage_acc[j-1]),
            .prev_coef (stage_coef[j-1]),
            .ctl_reg   (stage_ctl[j]),
            .acc_reg   (stage_acc[j]),
            .coef_reg  (stage_coef[j])
        );
    end

    assign valid               = stage_ctl[NSTEP].valid;
    assign result.point_index  = stage_ctl[NSTEP].point_index;
    assign result.value        = stage_acc[NSTEP];
    assign result.last_point   = stage_ctl[NSTEP].last_point;
    assign result.end_of_batch = stage_ctl[NSTEP].end_of_batch;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top;
    import pmeq_pkg::*;

    localparam int MAX_COEFFS = 10;

    class eval_scoreboard;
        logic      mod_sel;
        logic      len_sel;
        pmeq_out_t expected_points[$];
        int        errors;

        function new();
            mod_sel = 1'b0;
            len_sel = 1'b0;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_MODULUS)
            begin
                mod_sel = data[0];
            end
            else if (idx == REG_LENGTH)
            begin
                len_sel = data[0];
            end
        endfunction

        function int unsigned horner(int unsigned c[NCOEF_PORT], int unsigned n,
                                     int unsigned x, int unsigned q);
            int unsigned acc;
            int unsigned i;
            acc = 0;
            for (i = n; i > 0; i--)
            begin
                acc = (acc * x + c[i - 1]) % q;
            end
            return acc;
        endfunction

        function void push_point(int unsigned idx, int unsigned val, bit last, bit batch_end);
            pmeq_out_t p;
            p.point_index  = PIDX_W'(idx);
            p.value        = COEF_W'(val);
            p.last_point   = last;
            p.end_of_batch = last && batch_end;
            expected_points.push_back(p);
        endfunction

        function void note_column(pmeq_in_t it);
            int unsigned raw[NCOEF_PORT];
            int unsigned coef[NCOEF_PORT];
            int unsigned q;
            int unsigned n;
            int unsigned k;
            int unsigned xp;
            int unsigned xn;
            bit          batch_end;
            raw = '{32'(it.coeff_0), 32'(it.coeff_1), 32'(it.coeff_2), 32'(it.coeff_3),
                    32'(it.coeff_4), 32'(it.coeff_5), 32'(it.coeff_6), 32'(it.coeff_7),
                    32'(it.coeff_8), 32'(it.coeff_9)};
            q = 32'(mod_sel ? Q_HI : Q_LO);
            n = len_sel ? 32'(NCOEF_PORT) : 32'(LEN_SHORT);
            if (n > MAX_COEFFS)
            begin
                n = MAX_COEFFS;
            end
            batch_end = it.last_column;
            for (int i = 0; i < NCOEF_PORT; i++)
            begin
                coef[i] = (i < n) ? raw[i] % q : 0;
            end
            push_point(0, coef[0], (2 * n - 1) == 1, batch_end);
            for (k = 1; k + 2 <= n; k++)
            begin
                xp = k % q;
                xn = (q - xp) % q;
                push_point(2 * k - 1, horner(coef, n, xp, q), 1'b0, batch_end);
                push_point(2 * k, horner(coef, n, xn, q), 1'b0, batch_end);
            end
            push_point(2 * n - 3, horner(coef, n, (n - 1) % q, q), 1'b0, batch_end);
            push_point(2 * n - 2, coef[n - 1], 1'b1, batch_end);
        endfunction

        function void check_point(pmeq_out_t r);
            pmeq_out_t e;
            if (expected_points.size() == 0)
            begin
                $error("point_index %0d value %0d with no item outstanding",
                       r.point_index, r.value);
                errors++;
                return;
            end
            e = expected_points.pop_front();
            if (r.point_index !== e.point_index)
            begin
                $error("point_index: expected %0d, got %0d", e.point_index, r.point_index);
                errors++;
            end
            if (r.value !== e.value)
            begin
                $error("value: expected %0d, got %0d", e.value, r.value);
                errors++;
            end
            if (r.last_point !== e.last_point)
            begin
                $error("last_point: expected %0d, got %0d", e.last_point, r.last_point);
                errors++;
            end
            if (r.end_of_batch !== e.end_of_batch)
            begin
                $error("end_of_batch: expected %0d, got %0d", e.end_of_batch, r.end_of_batch);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_points.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pmeq_in_t              item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  valid;
    pmeq_out_t             result;

    eval_scoreboard sb;

    poly_multipoint_eval_mod_q_top #(
        .MAX_COEFFS (MAX_COEFFS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .valid     (valid),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                sb.note_column(item);
            end
            if (valid === 1'b1)
            begin
                sb.check_point(result);
            end
        end
    end

    function automatic pmeq_in_t make_column(logic [COEF_W-1:0] c[NCOEF_PORT], logic last);
        return '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], last};
    endfunction

    function automatic pmeq_in_t random_column(int unsigned q);
        logic [COEF_W-1:0] c[NCOEF_PORT];
        for (int i = 0; i < NCOEF_PORT; i++)
        begin
            case ($urandom_range(0, 9))
                0: c[i] = '0;
                1: c[i] = COEF_W'(q - 1);
                2: c[i] = 7'd126;
                default: c[i] = COEF_W'($urandom_range(0, 126));
            endcase
        end
        return make_column(c, $urandom_range(0, 3) == 0);
    endfunction

    function automatic pmeq_in_t directed_column(int p, int unsigned q);
        logic [COEF_W-1:0] c[NCOEF_PORT];
        for (int i = 0; i < NCOEF_PORT; i++)
        begin
            case (p)
                0: c[i] = '0;
                1: c[i] = COEF_W'(q - 1);
                2: c[i] = 7'd126;
                3: c[i] = COEF_W'(i * 14);
                default: c[i] = (i % 2 == 0) ? 7'h55 : 7'h2A;
            endcase
        end
        return make_column(c, p % 2 == 1);
    endfunction

    task automatic send_column(pmeq_in_t it, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_config(logic m, logic l);
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_COEFFS + 10) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODULUS;
        cfg_data  <= m;
        sb.write_reg(REG_MODULUS, m);
        @(posedge clk);
        cfg_index <= REG_LENGTH;
        cfg_data  <= l;
        sb.write_reg(REG_LENGTH, l);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap(bit idle_on);
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            return $urandom_range(1, 5);
        end
        return 0;
    endfunction

    initial
    begin
        int unsigned q;
        bit          idle_on;
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int s = 0; s < 4; s++)
        begin
            set_config(s[0], s[1]);
            q = 32'(sb.mod_sel ? Q_HI : Q_LO);
            for (int p = 0; p < 5; p++)
            begin
                send_column(directed_column(p, q), pick_gap(1'b1));
            end
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            q = 32'(sb.mod_sel ? Q_HI : Q_LO);
            idle_on = (ph % 2 == 0) && (ph != 7);
            for (int n = 0; n < 29; n++)
            begin
                send_column(random_column(q), pick_gap(idle_on));
            end
        end

        start <= 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_COEFFS + 20) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
